>>> rtl/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants for the IPv4 forwarding block
// Holds the stream widths, verdict codes, sequencer states, the route entry
// layout and the mask and checksum helper functions.
// ----------------------------------------------------------------------------
package lpm_pkg;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 56;

    localparam logic [1:0] VERDICT_LOCAL   = 2'd0;
    localparam logic [1:0] VERDICT_TTL     = 2'd1;
    localparam logic [1:0] VERDICT_NOROUTE = 2'd2;
    localparam logic [1:0] VERDICT_FORWARD = 2'd3;

    localparam logic       KIND_ROUTE  = 1'b0;
    localparam logic       KIND_HEADER = 1'b1;

    localparam logic [3:0]  IHL_MASK       = 4'hf;
    localparam logic [15:0] CSUM_ALL_ONES  = 16'hffff;
    localparam logic [5:0]  MAX_PREFIX_LEN = 6'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } scan_state_t;

    typedef struct packed {
        logic [31:0] hop;
        logic [5:0]  len;
        logic [31:0] prefix;
    } route_t;

    typedef struct packed {
        logic [31:0] destination;
        logic [7:0]  ttl;
        logic [3:0]  ihl;
        logic [20:0] running_sum;
    } hdr_info_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] next_hop;
        logic [7:0]  new_ttl;
        logic [15:0] new_checksum;
    } result_t;

    typedef struct packed {
        logic idle;
        logic load;
        logic hdr_clear;
    } scan_stat_t;

    function automatic logic [31:0] lpm_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0)
        begin
            m = 32'd0;
        end
        else if (len >= MAX_PREFIX_LEN)
        begin
            m = 32'hffff_ffff;
        end
        else
        begin
            m = ~(32'hffff_ffff >> len);
        end
        return m;
    endfunction

    // The TTL enters the sum only when its halfword lies inside the header.
    function automatic logic [15:0] lpm_csum(input logic [20:0] sum, input logic [3:0] ihl);
        logic [20:0] adj;
        logic [16:0] f1;
        logic [16:0] f2;
        adj = ((ihl & IHL_MASK) >= 4'd3) ? (sum - 21'h100) : sum;
        f1  = {12'd0, adj[20:16]} + {1'b0, adj[15:0]};
        f2  = {16'd0, f1[16]} + {1'b0, f1[15:0]};
        return CSUM_ALL_ONES - f2[15:0];
    endfunction

endpackage

>>> rtl/lpm_ram.sv
// ----------------------------------------------------------------------------
// lpm_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/lpm_hdr.sv
// ----------------------------------------------------------------------------
// lpm_hdr: IPv4 header halfword capture
// Tracks the halfword position, captures IHL, TTL and destination, and keeps
// the running ones-complement sum over the header.
// ----------------------------------------------------------------------------
module lpm_hdr (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               word_en,
    input  logic [15:0]        word,
    input  logic               clear,
    output lpm_pkg::hdr_info_t info
);

    import lpm_pkg::*;

    logic [5:0]  pos_reg, pos_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [7:0]  ttl_reg, ttl_next;
    logic [31:0] dest_reg, dest_next;
    logic [20:0] sum_reg, sum_next;
    logic [3:0]  ihl_eff;
    logic        sum_en;

    assign ihl_eff = (pos_reg == 6'd0) ? (word[11:8] & IHL_MASK) : ihl_reg;
    assign sum_en  = (pos_reg < {1'b0, ihl_eff, 1'b0}) && (pos_reg != 6'd5);

    always_comb
    begin
        pos_next  = pos_reg;
        ihl_next  = ihl_reg;
        ttl_next  = ttl_reg;
        dest_next = dest_reg;
        sum_next  = sum_reg;
        if (clear)
        begin
            pos_next  = 6'd0;
            ihl_next  = 4'd0;
            ttl_next  = 8'd0;
            dest_next = 32'd0;
            sum_next  = 21'd0;
        end
        else if (word_en && (pos_reg < 6'd32))
        begin
            ihl_next = ihl_eff;
            if (pos_reg == 6'd4)
            begin
                ttl_next = word[15:8];
            end
            if (pos_reg == 6'd8)
            begin
                dest_next = {word, dest_reg[15:0]};
            end
            if (pos_reg == 6'd9)
            begin
                dest_next = {dest_reg[31:16], word};
            end
            if (sum_en)
            begin
                sum_next = sum_reg + {5'd0, word};
            end
            pos_next = (pos_reg < 6'd31) ? (pos_reg + 6'd1) : 6'd32;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 6'd0;
            ihl_reg  <= 4'd0;
            ttl_reg  <= 8'd0;
            dest_reg <= 32'd0;
            sum_reg  <= 21'd0;
        end
        else
        begin
            pos_reg  <= pos_next;
            ihl_reg  <= ihl_next;
            ttl_reg  <= ttl_next;
            dest_reg <= dest_next;
            sum_reg  <= sum_next;
        end
    end

    assign info.destination = dest_reg;
    assign info.ttl         = ttl_reg;
    assign info.ihl         = ihl_reg;
    assign info.running_sum = sum_reg;

endmodule

>>> rtl/lpm_scan.sv
// ----------------------------------------------------------------------------
// lpm_scan: route table and longest prefix match sequencer
// Appends routes to the table memory and, for each packet needing a lookup,
// walks the stored entries one a cycle through a single masked compare unit.
// ----------------------------------------------------------------------------
module lpm_scan #(
    parameter int ENTRIES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                add_en,
    input  lpm_pkg::route_t     add_route,
    input  logic                start,
    input  lpm_pkg::hdr_info_t  hdr,
    input  logic [31:0]         local_address,
    input  logic                out_free,
    output lpm_pkg::scan_stat_t stat,
    output lpm_pkg::result_t    res
);

    import lpm_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    scan_state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          pend_reg;
    logic          found_reg, found_next;
    logic [5:0]    longest_reg, longest_next;
    logic [31:0]   hop_reg, hop_next;

    logic          wr_en;
    logic          rd_en;
    logic [$bits(route_t)-1:0] rd_data;
    route_t        entry;
    logic          scan_go;
    logic          last_idx;
    logic          hit;

    assign wr_en = add_en && (count_reg < CW'(ENTRIES));

    lpm_ram #(
        .WIDTH (($bits(route_t))),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (add_route),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign entry    = route_t'(rd_data);
    assign scan_go  = (hdr.destination != local_address) && (hdr.ttl != 8'd0)
                      && (count_reg != '0);
    assign last_idx = (CW'(idx_reg) == (count_reg - CW'(1)));
    assign hit      = pend_reg && (entry.len > longest_reg)
                      && (entry.prefix == (hdr.destination & lpm_mask(entry.len)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = scan_go ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        stat.idle      = (state_reg == ST_IDLE);
        stat.load      = (state_reg == ST_DONE) && out_free;
        stat.hdr_clear = (state_reg == ST_DONE) && out_free;
        rd_en          = (state_reg == ST_SCAN);
    end

    always_comb
    begin
        count_next   = wr_en ? (count_reg + CW'(1)) : count_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        longest_next = longest_reg;
        hop_next     = hop_reg;
        if (state_reg == ST_CHECK)
        begin
            idx_next     = '0;
            found_next   = 1'b0;
            longest_next = 6'd0;
        end
        else if (state_reg == ST_SCAN)
        begin
            idx_next = idx_reg + AW'(1);
        end
        if (hit)
        begin
            found_next   = 1'b1;
            longest_next = entry.len;
            hop_next     = entry.hop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            longest_reg <= 6'd0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            pend_reg    <= rd_en;
            found_reg   <= found_next;
            longest_reg <= longest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hop_reg <= hop_next;
    end

    always_comb
    begin
        res.verdict      = VERDICT_NOROUTE;
        res.next_hop     = 32'd0;
        res.new_ttl      = 8'd0;
        res.new_checksum = 16'd0;
        priority if (hdr.destination == local_address)
        begin
            res.verdict = VERDICT_LOCAL;
        end
        else if (hdr.ttl == 8'd0)
        begin
            res.verdict = VERDICT_TTL;
        end
        else if (found_reg)
        begin
            res.verdict      = VERDICT_FORWARD;
            res.next_hop     = hop_reg;
            res.new_ttl      = hdr.ttl - 8'd1;
            res.new_checksum = lpm_csum(hdr.running_sum, hdr.ihl);
        end
        else
        begin
            res.verdict = VERDICT_NOROUTE;
        end
    end

endmodule

>>> rtl/ipv4_forward_lpm.sv
// ----------------------------------------------------------------------------
// ipv4_forward_lpm: IPv4 forwarding decision with longest prefix match
// Builds a route table from route requests and decides each packet's fate
// from its header halfwords.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries route adds (tuser 0) and header halfwords
// (tuser 1, tlast on the final halfword). The master stream carries one
// decision per packet: verdict in tuser, next hop, new TTL and checksum
// in tdata. local_address is written through cfg_we and cfg_wdata.
// A route request or a non-final halfword is taken without dropping s_tready.
// After the final halfword the block drops s_tready while it decides:
// local and TTL verdicts, and any verdict while the route table is empty,
// skip the table walk; otherwise the route table is read one entry a
// cycle in the scan state, and a drain state follows the last read.
// The drain state covers the registered read port of the table memory.
// The decision lands in an output register; new requests are taken while
// it waits, but the next decision holds until the receiver takes it.
// Reset empties the route table, clears local_address and the packet
// state, and leaves the master stream idle.
// ----------------------------------------------------------------------------
module ipv4_forward_lpm #(
    parameter int ROUTE_ENTRIES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [31:0]                   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // route_prefix[31:0], route_length[37:32], route_next_hop[69:38],
    // header_word[85:70], zero fill [87:86]
    input  logic [lpm_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // next_hop[31:0], new_ttl[39:32], new_checksum[55:40]
    output logic [lpm_pkg::M_TDATA_W-1:0] m_tdata,
    // verdict
    output logic [1:0]                    m_tuser
);

    import lpm_pkg::*;

    logic [31:0] local_addr_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic        accept;
    logic        out_free;
    route_t      add_route;
    logic [5:0]  len_in;
    hdr_info_t   hdr;
    scan_stat_t  stat;
    result_t     res;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = stat.idle;

    assign len_in           = s_tdata[37:32];
    assign add_route.prefix = s_tdata[31:0];
    assign add_route.len    = (len_in > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : len_in;
    assign add_route.hop    = s_tdata[69:38];

    lpm_hdr u_hdr (
        .clk     (clk),
        .rst_n   (rst_n),
        .word_en (accept && (s_tuser == KIND_HEADER)),
        .word    (s_tdata[85:70]),
        .clear   (stat.hdr_clear),
        .info    (hdr)
    );

    lpm_scan #(
        .ENTRIES (ROUTE_ENTRIES)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .add_en        (accept && (s_tuser == KIND_ROUTE)),
        .add_route     (add_route),
        .start         (accept && (s_tuser == KIND_HEADER) && s_tlast),
        .hdr           (hdr),
        .local_address (local_addr_reg),
        .out_free      (out_free),
        .stat          (stat),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                local_addr_reg <= cfg_wdata;
            end
            if (stat.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.load)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.verdict;
    assign m_tdata  = {out_reg.new_checksum, out_reg.new_ttl, out_reg.next_hop};

endmodule

>>> rtl/lpm_checker.sv
// ----------------------------------------------------------------------------
// lpm_checker: port-level checks for the IPv4 forwarding block
// Watches the stream ports and flags protocol and decision-format errors.
// ----------------------------------------------------------------------------
module lpm_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lpm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [1:0]                    m_tuser
);

    import lpm_pkg::*;

    // A held decision stays unchanged until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("decision changed while stalled");

    // The final halfword of a packet always starts a busy decision phase.
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_HEADER) && s_tlast |=> !s_tready)
        else $error("request taken during decision");

    a_zero_unless_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != VERDICT_FORWARD) |-> (m_tdata == '0))
        else $error("non-forward decision carries data");

    // A forwarded packet had a nonzero TTL, so the decremented TTL never wraps.
    a_fwd_ttl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == VERDICT_FORWARD) |-> (m_tdata[39:32] != 8'hff))
        else $error("forwarded TTL wrapped");

endmodule

bind ipv4_forward_lpm lpm_checker u_lpm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
